// ===== rtl/pctd_pkg.sv =====
package pctd_pkg;

   // Fixed widths of the stream fields
   localparam int CODE_W     = 16;
   localparam int LEN_W      = 5;
   localparam int SYM_W      = 8;
   localparam int STAT_W     = 2;
   localparam int REQ_DATA_W = 32;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_DECODE = 1'b1
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DECODED  = 2'd0,
      ST_INSERTED = 2'd1,
      ST_FULL     = 2'd2,
      ST_INVALID  = 2'd3
   } status_type;

endpackage

// ===== rtl/pctd_node_mem.sv =====
module pctd_node_mem #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 27,
   parameter int AW    = 9
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pctd_walk_ctrl.sv =====
module pctd_walk_ctrl #(
   parameter int NODE_COUNT   = 512,
   parameter int MAX_CODE_LEN = 16,
   parameter int SYMBOL_BITS  = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // item side
   input  logic                           item_valid,
   output logic                           item_ready,
   input  pctd_pkg::func_type             func,
   input  logic [pctd_pkg::CODE_W-1:0]    code_bits,
   input  logic [pctd_pkg::LEN_W-1:0]     code_length,
   input  logic [pctd_pkg::SYM_W-1:0]     symbol,
   input  logic                           stream_bit,
   // node store
   output logic                           rd_en,
   output logic [$clog2(NODE_COUNT)-1:0]  rd_addr,
   input  logic [SYMBOL_BITS+2*$clog2(NODE_COUNT):0] rd_data,
   output logic                           wr_en,
   output logic [$clog2(NODE_COUNT)-1:0]  wr_addr,
   output logic [SYMBOL_BITS+2*$clog2(NODE_COUNT):0] wr_data,
   // result side
   output logic                           res_valid,
   input  logic                           res_ready,
   output pctd_pkg::status_type           res_status,
   output logic [pctd_pkg::SYM_W-1:0]     res_symbol
);

   localparam int IDX_W = $clog2(NODE_COUNT);
   localparam int CNT_W = $clog2(NODE_COUNT + 1);
   localparam int KW    = $clog2(MAX_CODE_LEN + 1);
   localparam int ENT_W = 1 + SYMBOL_BITS + 2 * IDX_W;
   localparam int SUM_W = CNT_W + KW;

   typedef enum logic [6:0] {
      S_INIT      = 7'b0000001,
      S_IDLE      = 7'b0000010,
      S_INS_CHK   = 7'b0000100,
      S_ALLOC     = 7'b0001000,
      S_DEC_CHILD = 7'b0010000,
      S_DEC_LABEL = 7'b0100000,
      S_SEND      = 7'b1000000
   } state_type;

   state_type                    state_ff, state_in;
   logic [IDX_W-1:0]             cur_ff, cur_in;
   logic [IDX_W-1:0]             walk_ff, walk_in;
   logic [CNT_W-1:0]             used_ff, used_in;
   logic [KW-1:0]                left_ff, left_in;
   logic [pctd_pkg::CODE_W-1:0]  code_ff, code_in;
   logic [SYMBOL_BITS-1:0]       sym_ff, sym_in;
   logic                         bit_ff, bit_in;
   pctd_pkg::status_type         res_status_ff, res_status_in;
   logic [pctd_pkg::SYM_W-1:0]   res_sym_ff, res_sym_in;

   logic                         rd_lab;
   logic [SYMBOL_BITS-1:0]       rd_label;
   logic [IDX_W-1:0]             rd_left, rd_right;
   logic [KW-1:0]                bit_pos;
   logic [pctd_pkg::CODE_W-1:0]  code_shift;
   logic                         ins_bit;
   logic [IDX_W-1:0]             ins_child, dec_child, new_idx;
   logic                         no_room;
   logic [KW-1:0]                len_clamp;

   assign rd_lab   = rd_data[ENT_W-1];
   assign rd_label = rd_data[ENT_W-2 -: SYMBOL_BITS];
   assign rd_right = rd_data[2*IDX_W-1 -: IDX_W];
   assign rd_left  = rd_data[IDX_W-1:0];

   // code bits above the field width read as zero through the shift
   assign bit_pos    = left_ff - KW'(1);
   assign code_shift = code_ff >> bit_pos;
   assign ins_bit    = code_shift[0];
   assign ins_child  = ins_bit ? rd_right : rd_left;
   assign dec_child  = bit_ff ? rd_right : rd_left;
   assign new_idx    = used_ff[IDX_W-1:0];
   assign no_room    = (SUM_W'(used_ff) + SUM_W'(left_ff)) > SUM_W'(NODE_COUNT);
   assign len_clamp  = (code_length > MAX_CODE_LEN) ? KW'(MAX_CODE_LEN) : KW'(code_length);

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      walk_in       = walk_ff;
      used_in       = used_ff;
      left_in       = left_ff;
      code_in       = code_ff;
      sym_in        = sym_ff;
      bit_in        = bit_ff;
      res_status_in = res_status_ff;
      res_sym_in    = res_sym_ff;
      item_ready    = 1'b0;
      res_valid     = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_data       = '0;

      case (state_ff)
         S_INIT: begin
            // clear the root entry
            wr_en    = 1'b1;
            wr_addr  = '0;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               rd_en = 1'b1;
               if (func == pctd_pkg::FUNC_INSERT) begin
                  rd_addr  = '0;
                  cur_in   = '0;
                  left_in  = len_clamp;
                  code_in  = code_bits;
                  sym_in   = SYMBOL_BITS'(symbol);
                  state_in = S_INS_CHK;
               end else begin
                  rd_addr  = walk_ff;
                  bit_in   = stream_bit;
                  state_in = S_DEC_CHILD;
               end
            end
         end
         S_INS_CHK: begin
            res_sym_in = '0;
            if (left_ff == '0) begin
               // label an existing node, keep its children
               wr_en         = 1'b1;
               wr_data       = {1'b1, sym_ff, rd_right, rd_left};
               res_status_in = pctd_pkg::ST_INSERTED;
               state_in      = S_SEND;
            end else if (ins_child != '0) begin
               // follow the existing child
               cur_in  = ins_child;
               left_in = left_ff - KW'(1);
               rd_en   = 1'b1;
               rd_addr = ins_child;
            end else if (no_room) begin
               res_status_in = pctd_pkg::ST_FULL;
               state_in      = S_SEND;
            end else begin
               // hook the first new node under the current one
               wr_en    = 1'b1;
               wr_data  = {rd_lab, rd_label,
                           ins_bit ? new_idx : rd_right,
                           ins_bit ? rd_left : new_idx};
               cur_in   = new_idx;
               used_in  = used_ff + CNT_W'(1);
               left_in  = left_ff - KW'(1);
               state_in = S_ALLOC;
            end
         end
         S_ALLOC: begin
            wr_en = 1'b1;
            if (left_ff == '0) begin
               wr_data       = {1'b1, sym_ff, {2*IDX_W{1'b0}}};
               res_status_in = pctd_pkg::ST_INSERTED;
               res_sym_in    = '0;
               state_in      = S_SEND;
            end else begin
               // fresh node with one child, the next one allocated
               wr_data  = {1'b0, {SYMBOL_BITS{1'b0}},
                           ins_bit ? new_idx : {IDX_W{1'b0}},
                           ins_bit ? {IDX_W{1'b0}} : new_idx};
               cur_in   = new_idx;
               used_in  = used_ff + CNT_W'(1);
               left_in  = left_ff - KW'(1);
            end
         end
         S_DEC_CHILD: begin
            if (dec_child == '0) begin
               walk_in       = '0;
               res_status_in = pctd_pkg::ST_INVALID;
               res_sym_in    = '0;
               state_in      = S_SEND;
            end else begin
               cur_in   = dec_child;
               rd_en    = 1'b1;
               rd_addr  = dec_child;
               state_in = S_DEC_LABEL;
            end
         end
         S_DEC_LABEL: begin
            if (rd_lab) begin
               walk_in       = '0;
               res_status_in = pctd_pkg::ST_DECODED;
               res_sym_in    = pctd_pkg::SYM_W'(rd_label);
               state_in      = S_SEND;
            end else begin
               walk_in  = cur_ff;
               state_in = S_IDLE;
            end
         end
         S_SEND: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         walk_ff  <= '0;
         used_ff  <= CNT_W'(1);
      end else begin
         state_ff <= state_in;
         walk_ff  <= walk_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      left_ff       <= left_in;
      code_ff       <= code_in;
      sym_ff        <= sym_in;
      bit_ff        <= bit_in;
      res_status_ff <= res_status_in;
      res_sym_ff    <= res_sym_in;
   end

   assign res_status = res_status_ff;
   assign res_symbol = res_sym_ff;

endmodule

// ===== rtl/prefix_code_tree_decoder.sv =====
// Prefix code tree decoder. Insert words (req_tuser low) build a binary code
// tree in a single-port-read node store; decode words (req_tuser high) walk it
// one stream bit at a time and return a symbol when a labelled node is reached,
// or an invalid-path status when the walk falls off the tree (the walk then
// restarts at the root). Every insert returns one word, inserted or table full;
// a decode bit that lands on an unlabelled node returns nothing. Items are taken
// one at a time. The node store has a registered read, and each tree
// level costs one read: an insert does one read per existing level, one
// write per new node and then posts the result; a decode bit reads the
// current node and then the child that the bit selects. One finished word is
// held in the output register, so the next item is taken while it waits.
// After reset the block clears the root before it accepts a word.
module prefix_code_tree_decoder #(
   parameter int NODE_COUNT   = 512,
   parameter int MAX_CODE_LEN = 16,
   parameter int SYMBOL_BITS  = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // code_bits[15:0], code_length[20:16], symbol[28:21], stream_bit[29], zero[31:30]
   input  logic [pctd_pkg::REQ_DATA_W-1:0]   req_tdata,
   // func[0]
   input  logic                              req_tuser,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // decoded_symbol[7:0]
   output logic [pctd_pkg::SYM_W-1:0]        rsp_tdata,
   // status[1:0]
   output logic [pctd_pkg::STAT_W-1:0]       rsp_tuser
);

   localparam int IDX_W = $clog2(NODE_COUNT);
   localparam int ENT_W = 1 + SYMBOL_BITS + 2 * IDX_W;

   // unpack the request word
   logic [pctd_pkg::CODE_W-1:0] req_code_bits;
   logic [pctd_pkg::LEN_W-1:0]  req_code_length;
   logic [pctd_pkg::SYM_W-1:0]  req_symbol;
   logic                        req_stream_bit;

   assign req_code_bits   = req_tdata[15:0];
   assign req_code_length = req_tdata[20:16];
   assign req_symbol      = req_tdata[28:21];
   assign req_stream_bit  = req_tdata[29];

   logic                        rd_en, wr_en;
   logic [IDX_W-1:0]            rd_addr, wr_addr;
   logic [ENT_W-1:0]            rd_data, wr_data;

   logic                        res_valid, res_ready;
   pctd_pkg::status_type        res_status;
   logic [pctd_pkg::SYM_W-1:0]  res_symbol;

   logic                        rsp_valid_ff, rsp_valid_in;
   pctd_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [pctd_pkg::SYM_W-1:0]  rsp_symbol_ff, rsp_symbol_in;

   pctd_node_mem #(
      .DEPTH (NODE_COUNT),
      .WIDTH (ENT_W),
      .AW    (IDX_W)
   ) u_node_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   pctd_walk_ctrl #(
      .NODE_COUNT   (NODE_COUNT),
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .SYMBOL_BITS  (SYMBOL_BITS)
   ) u_walk_ctrl (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (req_tvalid),
      .item_ready  (req_tready),
      .func        (pctd_pkg::func_type'(req_tuser)),
      .code_bits   (req_code_bits),
      .code_length (req_code_length),
      .symbol      (req_symbol),
      .stream_bit  (req_stream_bit),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_status  (res_status),
      .res_symbol  (res_symbol)
   );

   // output register: load when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_symbol_in = rsp_symbol_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_status_in = res_status;
            rsp_symbol_in = res_symbol;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_symbol_ff <= rsp_symbol_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_symbol_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
